// ----- hw/rtl/fifo_page_replacement_macros.svh -----
// ----------------------------------------------------------------------------
// FIFO page replacement assertion macros
// Shorthand for the concurrent checks of the page replacement block.
// ----------------------------------------------------------------------------
`ifndef FIFO_PAGE_REPLACEMENT_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_MACROS_SVH

// Check a condition that must hold in the same cycle as its trigger
`define FPR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition that must hold in the cycle after its trigger
`define FPR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fpr_pkg.sv -----
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Fixed field widths, register reset value and the link between frame cells.
// ----------------------------------------------------------------------------
package fpr_pkg;

    // Width of the frames-in-use register
    localparam int FIU_W = 5;
    // Reset value of the frames-in-use register
    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
    // Width of the hit and fault counters
    localparam int CNT_W = 16;
    // Width of the reported frame index
    localparam int FRAME_OUT_W = 4;

    // Flags handed from one frame cell to the next
    typedef struct packed {
        logic hit;       // some earlier frame matched the page
        logic ev_valid;  // victim frame held a resident page
    } fpr_link_t;

endpackage

// ----- hw/rtl/fpr_frame_cell.sv -----
// ----------------------------------------------------------------------------
// FIFO page replacement frame cell
// Holds one page frame, compares it against the looked-up page and passes
// the running hit flag and victim contents on to the next cell.
// ----------------------------------------------------------------------------
module fpr_frame_cell #(
    parameter int IDX       = 0,
    parameter int IDX_W     = 4,
    parameter int CW        = 5,
    parameter int PAGE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [PAGE_BITS-1:0]   page,
    input  logic [CW-1:0]          count,
    input  logic [IDX_W-1:0]       victim,
    input  logic                   fill,
    input  fpr_pkg::fpr_link_t     link_in,
    input  logic [PAGE_BITS-1:0]   ev_page_in,
    output fpr_pkg::fpr_link_t     link_out,
    output logic [PAGE_BITS-1:0]   ev_page_out
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 active;
    logic                 is_victim;
    logic                 match;

    // Frame takes part only below the effective count
    assign active    = CW'(IDX) < count;
    assign is_victim = victim == IDX_W'(IDX);
    assign match     = active && valid_reg && (page_reg == page);

    // Merge this frame into the chain
    assign link_out.hit      = link_in.hit || match;
    assign link_out.ev_valid = is_victim ? valid_reg : link_in.ev_valid;
    assign ev_page_out       = is_victim ? (valid_reg ? page_reg : '0) : ev_page_in;

    // Valid bit: set once the frame is filled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fill && is_victim)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Page store: load on a fault aimed at this frame
    always_ff @(posedge clk)
    begin
        if (fill && is_victim)
        begin
            page_reg <= page;
        end
    end

endmodule

// ----- hw/rtl/fpr_sat_counter.sv -----
// ----------------------------------------------------------------------------
// FIFO page replacement saturating counter
// Counts events and holds at the all-ones value.
// ----------------------------------------------------------------------------
module fpr_sat_counter #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         inc,
    output logic [W-1:0] count
);

    logic [W-1:0] count_reg;
    logic [W-1:0] count_next;

    // Advance unless full
    always_comb
    begin
        count_next = count_reg;
        if (inc && (count_reg != {W{1'b1}}))
        begin
            count_next = count_reg + W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ----- hw/rtl/fifo_page_replacement.sv -----
// ----------------------------------------------------------------------------
// FIFO page replacement
// Looks up one page reference per beat across a row of frame cells, refills
// the round-robin victim frame on a fault and reports hit, fill and eviction.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | page_number
//  output   | out_valid / out_stall| is_hit, filled_frame, evicted_valid,
//           |                      | evicted_page, total_hits, total_faults
//  config   | cfg_we               | cfg_wdata (frames in use)
//
//  One reference per cycle unless a held result is stalled: the compare runs through the frame cell row and
//  the frame, pointer and counters update at the accepting edge.
//  The result appears in the output register in the cycle after acceptance.
//  A new beat is taken in the same cycle the held result is taken.
//  Reset empties every frame and clears pointer and counters; frames in use
//  returns to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "fifo_page_replacement_macros.svh"

module fifo_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [PAGE_BITS-1:0]                 page_number,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 is_hit,
    output logic [fpr_pkg::FRAME_OUT_W-1:0]      filled_frame,
    output logic                                 evicted_valid,
    output logic [PAGE_BITS-1:0]                 evicted_page,
    output logic [fpr_pkg::CNT_W-1:0]            total_hits,
    output logic [fpr_pkg::CNT_W-1:0]            total_faults,
    input  logic                                 cfg_we,
    input  logic [fpr_pkg::FIU_W-1:0]            cfg_wdata
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FW    = $clog2(FRAMES + 1);
    localparam int CW    = (FW > fpr_pkg::FIU_W) ? FW : fpr_pkg::FIU_W;
    localparam int XW    = (IDX_W > fpr_pkg::FRAME_OUT_W) ? IDX_W : fpr_pkg::FRAME_OUT_W;

    logic [fpr_pkg::FIU_W-1:0] fiu_reg;
    logic [IDX_W-1:0]          ptr_reg;
    logic [IDX_W-1:0]          ptr_next;
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [fpr_pkg::FRAME_OUT_W-1:0] filled_reg;
    logic                      ev_valid_reg;
    logic [PAGE_BITS-1:0]      ev_page_reg;

    logic                      accept;
    logic                      hit_w;
    logic                      fill;
    logic [CW-1:0]             fiu_ext;
    logic [CW-1:0]             count;
    logic [IDX_W-1:0]          victim;
    logic [CW-1:0]             victim_inc;
    logic [XW-1:0]             victim_x;

    fpr_pkg::fpr_link_t        link [FRAMES+1];
    logic [PAGE_BITS-1:0]      ev_page [FRAMES+1];

    // Take a beat unless a held result is blocked
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Effective frame count: zero acts as one, clamp at FRAMES
    assign fiu_ext = CW'(fiu_reg);
    always_comb
    begin
        count = fiu_ext;
        if (fiu_ext == '0)
        begin
            count = CW'(1);
        end
        else if (fiu_ext > CW'(FRAMES))
        begin
            count = CW'(FRAMES);
        end
    end

    // Victim: pointer, or frame 0 once the count shrank below it
    assign victim     = (CW'(ptr_reg) >= count) ? '0 : ptr_reg;
    assign victim_inc = CW'(victim) + CW'(1);
    assign ptr_next   = (victim_inc >= count) ? '0 : victim_inc[IDX_W-1:0];

    // Frame cell row
    assign link[0]    = '0;
    assign ev_page[0] = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        fpr_frame_cell #(
            .IDX       (i),
            .IDX_W     (IDX_W),
            .CW        (CW),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .page        (page_number),
            .count       (count),
            .victim      (victim),
            .fill        (fill),
            .link_in     (link[i]),
            .ev_page_in  (ev_page[i]),
            .link_out    (link[i+1]),
            .ev_page_out (ev_page[i+1])
        );
    end

    assign hit_w = link[FRAMES].hit;
    assign fill  = accept && !hit_w;

    // Hit and fault counters
    fpr_sat_counter #(.W(fpr_pkg::CNT_W)) u_hits (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (accept && hit_w),
        .count (total_hits)
    );

    fpr_sat_counter #(.W(fpr_pkg::CNT_W)) u_faults (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (fill),
        .count (total_faults)
    );

    // Frames-in-use register and replace pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg <= fpr_pkg::FIU_RESET;
            ptr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fiu_reg <= cfg_wdata;
            end
            if (fill)
            begin
                ptr_reg <= ptr_next;
            end
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: load on accept
    assign victim_x = XW'(victim);
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= hit_w;
            filled_reg   <= hit_w ? '0 : victim_x[fpr_pkg::FRAME_OUT_W-1:0];
            ev_valid_reg <= !hit_w && link[FRAMES].ev_valid;
            ev_page_reg  <= hit_w ? '0 : ev_page[FRAMES];
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_hit        = hit_reg;
    assign filled_frame  = filled_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;

    // Checks
    `FPR_ASSERT_IMP(a_hit_no_fill, out_valid && is_hit, (filled_frame == '0) && !evicted_valid && (evicted_page == '0), "hit result reports a fill or eviction")
    `FPR_ASSERT_NXT(a_hit_keeps_faults, accept && hit_w, total_faults == $past(total_faults), "fault count moved on a hit")
    `FPR_ASSERT_NXT(a_fault_moves_ptr, fill && (count > CW'(1)), ptr_reg != $past(victim), "replace pointer stuck on a fault")

endmodule

// ----- dv/fpr_checker.sv -----
// ----------------------------------------------------------------------------
// FIFO page replacement checker
// Watches the reference, result and configuration ports of the page
// replacement block, keeps its own copy of frames, pointer and counters, and
// compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fpr_checker #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [PAGE_BITS-1:0]            page_number,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            is_hit,
    input  logic [fpr_pkg::FRAME_OUT_W-1:0] filled_frame,
    input  logic                            evicted_valid,
    input  logic [PAGE_BITS-1:0]            evicted_page,
    input  logic [fpr_pkg::CNT_W-1:0]       total_hits,
    input  logic [fpr_pkg::CNT_W-1:0]       total_faults,
    input  logic                            cfg_we,
    input  logic [fpr_pkg::FIU_W-1:0]       cfg_wdata,
    output int                              fail_count,
    output int                              pending
);

    // Keep the report short when the block is badly broken
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic                            is_hit;
        logic [fpr_pkg::FRAME_OUT_W-1:0] filled_frame;
        logic                            evicted_valid;
        logic [PAGE_BITS-1:0]            evicted_page;
        logic [fpr_pkg::CNT_W-1:0]       total_hits;
        logic [fpr_pkg::CNT_W-1:0]       total_faults;
    } page_result_t;

    // Shadow of the frame table, victim pointer, counters and register
    logic [PAGE_BITS-1:0]        slot_page [FRAMES];
    logic                        slot_valid [FRAMES];
    int                          next_victim;
    logic [fpr_pkg::CNT_W-1:0]   hit_total;
    logic [fpr_pkg::CNT_W-1:0]   fault_total;
    logic [fpr_pkg::FIU_W-1:0]   frames_cfg;

    page_result_t         lookup_results [$];
    int                   errors;

    // Look up one reference, update the shadow table and return its result
    function automatic page_result_t lookup_page(input logic [PAGE_BITS-1:0] page);
        page_result_t r;
        int           span;
        int           victim;
        logic         found;
        span = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
        found = 1'b0;
        r = '0;
        for (int i = 0; i < span; i++)
        begin
            if (slot_valid[i] && slot_page[i] == page)
                found = 1'b1;
        end
        if (found)
        begin
            r.is_hit = 1'b1;
            if (hit_total != '1)
                hit_total++;
        end
        else
        begin
            // Fall back to frame 0 when the pointer sits past a shrunken count
            victim = (next_victim >= span) ? 0 : next_victim;
            if (fault_total != '1)
                fault_total++;
            if (slot_valid[victim])
            begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = slot_page[victim];
            end
            slot_page[victim]  = page;
            slot_valid[victim] = 1'b1;
            r.filled_frame     = fpr_pkg::FRAME_OUT_W'(victim);
            next_victim        = (victim + 1 >= span) ? 0 : victim + 1;
        end
        r.total_hits   = hit_total;
        r.total_faults = fault_total;
        return r;
    endfunction

    // Count a field mismatch and report it while the report is short
    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Compare result beats, predict reference beats, then track configuration
    always @(posedge clk or negedge rst_n)
    begin
        page_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                slot_page[i]  = '0;
                slot_valid[i] = 1'b0;
            end
            next_victim = 0;
            hit_total   = '0;
            fault_total = '0;
            frames_cfg  = fpr_pkg::FIU_RESET;
            lookup_results.delete();
            errors      = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Compare before predicting so a result can never match its own beat
            if (out_valid && !out_stall)
            begin
                if (lookup_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: unexpected result, expected none, got hit=%0b",
                                  " frame=%0d ev=%0b page=%0h hits=%0d faults=%0d"},
                                 $time, is_hit, filled_frame, evicted_valid, evicted_page,
                                 total_hits, total_faults);
                end
                else
                begin
                    want = lookup_results.pop_front();
                    check_field("is_hit", want.is_hit, is_hit);
                    check_field("filled_frame", want.filled_frame, filled_frame);
                    check_field("evicted_valid", want.evicted_valid, evicted_valid);
                    check_field("evicted_page", want.evicted_page, evicted_page);
                    check_field("total_hits", want.total_hits, total_hits);
                    check_field("total_faults", want.total_faults, total_faults);
                end
            end

            // A beat taken at this edge still sees the old frame count
            if (in_valid && !in_stall)
                lookup_results.push_back(lookup_page(page_number));

            if (cfg_we)
                frames_cfg = cfg_wdata;

            pending    <= lookup_results.size();
            fail_count <= errors;
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// FIFO page replacement testbench
// Drives page references through the block under random sender gaps and
// receiver stalls, across several frame counts including the out-of-range
// ones, with a long receiver hold-off and a final run without idling.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAMES      = 16;
    localparam int PAGE_BITS   = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_REFS  = 180;
    localparam int QUIET_REFS  = 200;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [PAGE_BITS-1:0]            page_number = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            is_hit;
    logic [fpr_pkg::FRAME_OUT_W-1:0] filled_frame;
    logic                            evicted_valid;
    logic [PAGE_BITS-1:0]            evicted_page;
    logic [fpr_pkg::CNT_W-1:0]       total_hits;
    logic [fpr_pkg::CNT_W-1:0]       total_faults;
    logic                            cfg_we = 1'b0;
    logic [fpr_pkg::FIU_W-1:0]       cfg_wdata = '0;

    int                     fail_count;
    int                     pending;
    int                     cycle_count = 0;
    bit                     receiver_hold = 1'b0;
    bit                     quiet = 1'b0;

    always #5 clk = ~clk;

    fifo_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_hit        (is_hit),
        .filled_frame  (filled_frame),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .total_hits    (total_hits),
        .total_faults  (total_faults),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    fpr_checker #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_hit        (is_hit),
        .filled_frame  (filled_frame),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .total_hits    (total_hits),
        .total_faults  (total_faults),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one reference beat, maybe after an idle burst, and hold it until taken
    task automatic offer_page(input logic [PAGE_BITS-1:0] page);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= page;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop offering and wait for every predicted result to come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Write the frames-in-use register while the block is idle
    task automatic set_frames(input logic [fpr_pkg::FIU_W-1:0] count);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Send references drawn mostly from a small working set, the rest random
    task automatic run_refs(input int refs, input int hold_at, input int pool_size);
        logic [PAGE_BITS-1:0] working_set [$];
        logic [PAGE_BITS-1:0] page;
        for (int i = 0; i < pool_size; i++)
            working_set.push_back(PAGE_BITS'($urandom));
        for (int i = 0; i < refs; i++)
        begin
            if (i == hold_at)
                receiver_hold = 1'b1;
            if ($urandom_range(0, 9) < 7)
                page = working_set[$urandom_range(0, pool_size - 1)];
            else
                page = PAGE_BITS'($urandom);
            offer_page(page);
        end
    endtask

    // Stall the result side in random bursts, or hold it off for a long stretch
    initial
    begin
        int burst;
        forever
        begin
            if (receiver_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                receiver_hold = 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 12);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (burst) @(posedge clk);
            end
        end
    end

    // Main stimulus
    initial
    begin
        logic [fpr_pkg::FIU_W-1:0] phase_frames [10];
        int                        span;
        phase_frames = '{5'd1, 5'd16, 5'd5, 5'd0, 5'd31, 5'd17, 5'd3, 5'd9, 5'd8, 5'd16};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Fill from empty at the reset frame count, then hit the extremes
        offer_page(16'h0000);
        offer_page(16'hFFFF);
        offer_page(16'h0000);
        offer_page(16'hFFFF);
        offer_page(16'h00A5);
        offer_page(16'h5A00);

        // Shrink below the pointer: victim falls back to frame 0
        drain();
        set_frames(5'd2);
        offer_page(16'h1234);
        offer_page(16'hFFFF);
        offer_page(16'h00A5);

        // Zero frames acts as one
        drain();
        set_frames(5'd0);
        offer_page(16'h1234);
        offer_page(16'h4321);
        offer_page(16'h4321);

        // Grow past the top: hidden frames come back, count clamps to the maximum
        drain();
        set_frames(5'd31);
        offer_page(16'h5A00);
        offer_page(16'h00A5);
        offer_page(16'h7777);
        drain();
        set_frames(5'd17);
        offer_page(16'h7777);
        offer_page(16'h8001);

        // Random phases over several frame counts; one carries the long hold-off
        for (int i = 0; i < 10; i++)
        begin
            if (i == 7)
                phase_frames[i] = fpr_pkg::FIU_W'($urandom_range(2, 15));
            drain();
            set_frames(phase_frames[i]);
            span = (phase_frames[i] == 0) ? 1 :
                   ((phase_frames[i] > FRAMES) ? FRAMES : int'(phase_frames[i]));
            run_refs(PHASE_REFS, (i == 1) ? 50 : -1, span + $urandom_range(0, span));
        end

        // Close with a run that never idles on either side
        drain();
        quiet = 1'b1;
        set_frames(5'd8);
        run_refs(QUIET_REFS, -1, 12);

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_frame_cell.sv
hw/rtl/fpr_sat_counter.sv
hw/rtl/fifo_page_replacement.sv
dv/fpr_checker.sv
dv/tb_top.sv
